// File: rtl/core/swpw_pkg.sv
// Package of shared types, constants and segment functions for the pulse-width byte sender.
`timescale 1ns / 1ps
`default_nettype none

package swpw_pkg;

  localparam int TickCountBits = 12;
  localparam int BitsPerFrame  = 8;
  localparam int RegBits       = 12;
  localparam int DataBits      = 8;
  localparam int DataIdxBits   = $clog2(DataBits);
  localparam int LastSeg       = 2 * BitsPerFrame + 2;
  localparam int SegBits       = $clog2(LastSeg + 1);
  localparam int CfgIdxBits    = 3;
  localparam logic [31:0] TickMax = 32'((64'd1 << TickCountBits) - 64'd1);

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_SEND  = 2'd1,
    CMD_LEVEL = 2'd2
  } cmd_t;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_START_HIGH = 3'd0,
    CFG_ZERO_LOW   = 3'd1,
    CFG_ZERO_HIGH  = 3'd2,
    CFG_ONE_LOW    = 3'd3,
    CFG_ONE_HIGH   = 3'd4,
    CFG_END_LOW    = 3'd5,
    CFG_END_HIGH   = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic [RegBits-1:0] start_high_ticks;
    logic [RegBits-1:0] zero_low_ticks;
    logic [RegBits-1:0] zero_high_ticks;
    logic [RegBits-1:0] one_low_ticks;
    logic [RegBits-1:0] one_high_ticks;
    logic [RegBits-1:0] end_low_ticks;
    logic [RegBits-1:0] end_high_ticks;
  } cfg_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
    logic rejected;
  } res_t;

  function automatic logic seg_bit(logic [SegBits-1:0] seg, logic [DataBits-1:0] shift);
    int idx;
    int pos;
    idx = (int'(seg) - 1) >>> 1;
    pos = BitsPerFrame - 1 - idx;
    if (pos >= 0 && pos < DataBits) begin
      return shift[pos[DataIdxBits-1:0]];
    end
    return 1'b0;
  endfunction

  function automatic logic seg_level(logic [SegBits-1:0] seg);
    if (seg == '0) begin
      return 1'b1;
    end
    if (seg == SegBits'(LastSeg - 1)) begin
      return 1'b0;
    end
    if (seg >= SegBits'(LastSeg)) begin
      return 1'b1;
    end
    return ~seg[0];
  endfunction

  function automatic logic [TickCountBits-1:0] seg_length(logic [SegBits-1:0] seg,
                                                           logic [DataBits-1:0] shift,
                                                           cfg_t cfg);
    logic [RegBits-1:0] len;
    logic [TickCountBits-1:0] sat;
    logic b;
    b = seg_bit(seg, shift);
    if (seg == '0) begin
      len = cfg.start_high_ticks;
    end else if (seg == SegBits'(LastSeg - 1)) begin
      len = cfg.end_low_ticks;
    end else if (seg >= SegBits'(LastSeg)) begin
      len = cfg.end_high_ticks;
    end else if (seg[0]) begin
      len = b ? cfg.one_low_ticks : cfg.zero_low_ticks;
    end else begin
      len = b ? cfg.one_high_ticks : cfg.zero_high_ticks;
    end
    if (32'(len) > TickMax) begin
      sat = TickCountBits'(TickMax);
    end else begin
      sat = TickCountBits'(len);
    end
    if (sat == '0) begin
      sat = TickCountBits'(1);
    end
    return sat;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/swpw_cmd_if.sv
// Interface of the command channel: valid, ready and the command word.
`timescale 1ns / 1ps
`default_nettype none

interface swpw_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink (input valid, input command, input data_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/core/swpw_res_if.sv
// Interface of the result channel: valid, ready and the result word.
`timescale 1ns / 1ps
`default_nettype none

interface swpw_res_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic frame_done;
  logic rejected;

  modport source (output valid, output line_level, output busy_res, output frame_done,
                  output rejected, input ready);
  modport sink (input valid, input line_level, input busy_res, input frame_done,
                input rejected, output ready);
endinterface

`default_nettype wire

// File: rtl/core/swpw_cfg_regs.sv
// Segment length registers with their reset values and the write port.
`timescale 1ns / 1ps
`default_nettype none

module swpw_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [swpw_pkg::CfgIdxBits-1:0]    cfg_index,
  input  wire logic [swpw_pkg::RegBits-1:0]       cfg_data,
  output swpw_pkg::cfg_t                          cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_high_ticks <= swpw_pkg::RegBits'(100);
      cfg.zero_low_ticks   <= swpw_pkg::RegBits'(15);
      cfg.zero_high_ticks  <= swpw_pkg::RegBits'(5);
      cfg.one_low_ticks    <= swpw_pkg::RegBits'(5);
      cfg.one_high_ticks   <= swpw_pkg::RegBits'(15);
      cfg.end_low_ticks    <= swpw_pkg::RegBits'(5);
      cfg.end_high_ticks   <= swpw_pkg::RegBits'(400);
    end else if (cfg_we) begin
      unique case (cfg_index)
        swpw_pkg::CFG_START_HIGH: cfg.start_high_ticks <= cfg_data;
        swpw_pkg::CFG_ZERO_LOW:   cfg.zero_low_ticks   <= cfg_data;
        swpw_pkg::CFG_ZERO_HIGH:  cfg.zero_high_ticks  <= cfg_data;
        swpw_pkg::CFG_ONE_LOW:    cfg.one_low_ticks    <= cfg_data;
        swpw_pkg::CFG_ONE_HIGH:   cfg.one_high_ticks   <= cfg_data;
        swpw_pkg::CFG_END_LOW:    cfg.end_low_ticks    <= cfg_data;
        swpw_pkg::CFG_END_HIGH:   cfg.end_high_ticks   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/swpw_seq.sv
// Frame sequencer: segment state registers and the per-tick update logic.
`timescale 1ns / 1ps
`default_nettype none

module swpw_seq (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            fire,
  input  wire logic [1:0]                      command,
  input  wire logic [swpw_pkg::DataBits-1:0]   data_byte,
  input  wire swpw_pkg::cfg_t                  cfg,
  output swpw_pkg::res_t                       result
);

  logic                                  line_out;
  logic                                  sending;
  logic [swpw_pkg::SegBits-1:0]          segment_index;
  logic [swpw_pkg::TickCountBits-1:0]    ticks_left;
  logic [swpw_pkg::DataBits-1:0]         shift_byte;

  logic                                  line_out_next;
  logic                                  sending_next;
  logic [swpw_pkg::SegBits-1:0]          segment_index_next;
  logic [swpw_pkg::TickCountBits-1:0]    ticks_left_next;
  logic [swpw_pkg::DataBits-1:0]         shift_byte_next;

  logic                                  cmd_act;
  logic                                  done;
  logic [swpw_pkg::TickCountBits-1:0]    dec;

  always_comb begin
    line_out_next      = line_out;
    sending_next       = sending;
    segment_index_next = segment_index;
    ticks_left_next    = ticks_left;
    shift_byte_next    = shift_byte;
    done               = 1'b0;
    dec                = '0;

    cmd_act = (command == swpw_pkg::CMD_SEND) || (command == swpw_pkg::CMD_LEVEL);

    if (!sending) begin
      if (command == swpw_pkg::CMD_SEND) begin
        shift_byte_next    = data_byte;
        sending_next       = 1'b1;
        segment_index_next = '0;
        ticks_left_next    = swpw_pkg::seg_length('0, data_byte, cfg);
      end else if (command == swpw_pkg::CMD_LEVEL) begin
        line_out_next = data_byte[0];
      end
    end

    if (sending_next) begin
      line_out_next = swpw_pkg::seg_level(segment_index_next);
      dec = (ticks_left_next != '0) ? ticks_left_next - swpw_pkg::TickCountBits'(1) : '0;
      ticks_left_next = dec;
      if (dec == '0) begin
        if (segment_index_next >= swpw_pkg::SegBits'(swpw_pkg::LastSeg)) begin
          sending_next       = 1'b0;
          done               = 1'b1;
          line_out_next      = 1'b1;
          segment_index_next = '0;
        end else begin
          segment_index_next = segment_index_next + swpw_pkg::SegBits'(1);
          ticks_left_next    = swpw_pkg::seg_length(segment_index_next, shift_byte_next, cfg);
        end
      end
    end

    result.line_level = line_out_next;
    result.busy_res   = sending_next;
    result.frame_done = done;
    result.rejected   = cmd_act && sending;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_out      <= 1'b0;
      sending       <= 1'b0;
      segment_index <= '0;
      ticks_left    <= '0;
      shift_byte    <= '0;
    end else if (fire) begin
      line_out      <= line_out_next;
      sending       <= sending_next;
      segment_index <= segment_index_next;
      ticks_left    <= ticks_left_next;
      shift_byte    <= shift_byte_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/swpw_res_buf.sv
// Two-entry result queue: output register plus skid register.
`timescale 1ns / 1ps
`default_nettype none

module swpw_res_buf (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire swpw_pkg::res_t push_data,
  output logic                in_ready,
  output logic                head_valid,
  output swpw_pkg::res_t      head,
  input  wire logic           out_ready
);

  logic           skid_valid;
  swpw_pkg::res_t skid;
  logic           pop;

  assign pop      = head_valid && out_ready;
  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!head_valid) begin
        head_valid <= push;
      end else if (pop) begin
        if (skid_valid) begin
          skid_valid <= push;
        end else begin
          head_valid <= push;
        end
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!head_valid || (pop && !skid_valid)) begin
      head <= push_data;
    end else if (pop) begin
      head <= skid;
    end
    if (push && (skid_valid || (head_valid && !pop))) begin
      skid <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/single_wire_pulse_width_byte_sender_core.sv
// Top level of the single-wire pulse-width byte sender.
// Each command word is one tick of line timing: a send command frames a byte as a start high,
// eight bits MSB first (low then high, the lengths chosen by the bit value) and an end low and
// end high, after which the line idles high; a level command sets the idle level, and a send or
// level command during a frame is flagged as rejected. One command word is accepted in every
// cycle while the result queue has room; its result word is registered in the queue's output
// register, or in its skid register while an unread word waits there. The two-entry queue keeps
// the command channel ready while one result waits. The user writes segment lengths through the
// configuration port only while the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module single_wire_pulse_width_byte_sender_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  swpw_cmd_if.sink                               cmd,
  swpw_res_if.source                             res,
  input  wire logic                              cfg_we,
  input  wire logic [swpw_pkg::CfgIdxBits-1:0]   cfg_index,
  input  wire logic [swpw_pkg::RegBits-1:0]      cfg_data
);

  swpw_pkg::cfg_t cfg;
  swpw_pkg::res_t result;
  swpw_pkg::res_t head;
  logic           buf_ready;
  logic           fire;

  assign cmd.ready = buf_ready;
  assign fire      = cmd.valid && buf_ready;

  swpw_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  swpw_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .command   (cmd.command),
    .data_byte (cmd.data_byte),
    .cfg       (cfg),
    .result    (result)
  );

  swpw_res_buf u_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (fire),
    .push_data  (result),
    .in_ready   (buf_ready),
    .head_valid (res.valid),
    .head       (head),
    .out_ready  (res.ready)
  );

  assign res.line_level = head.line_level;
  assign res.busy_res   = head.busy_res;
  assign res.frame_done = head.frame_done;
  assign res.rejected   = head.rejected;

  // A finished frame leaves the line high and the sender idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.frame_done |-> res.line_level && !res.busy_res)
    else $error("frame end word shows a busy sender or a low line");

  // A rejection only happens during a frame, which may end on that same tick.
  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.rejected |-> res.busy_res || res.frame_done)
    else $error("rejected word while the sender was idle");

  // The queue stalls the command side only while a result word is waiting.
  a_stall_has_word: assert property (@(posedge clk) disable iff (rst)
    !cmd.ready |-> res.valid)
    else $error("command channel stalled with no result word pending");

endmodule

`default_nettype wire
